/* rtl/ncrt_pkg.sv */
package ncrt_pkg;

	localparam int TABLE_BITS_DEF = 10;
	localparam int ID_STEP_DEF    = 1;
	localparam int COUNT_BITS_DEF = 8;

	localparam int ID_W       = 32;
	localparam int POOL_W     = 8;
	localparam int CNT_IN_W   = 32;
	localparam int POOL_BITS_W = 3;
	localparam logic [POOL_BITS_W-1:0] POOL_BITS_MAX = 3'd4;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [2:0] {
		STATUS_OK       = 3'd0,
		STATUS_BAD_POOL = 3'd1,
		STATUS_AGED     = 3'd2,
		STATUS_TOO_BIG  = 3'd3,
		STATUS_REPLAY   = 3'd4
	} status_t;

	typedef enum logic {
		CMD_NEW   = 1'b0,
		CMD_CHECK = 1'b1
	} cmd_t;

endpackage

/* rtl/nonce_count_replay_table_core.sv */
// order: stage 1 takes the word and its table read, then the output register takes the result
// throughput: one word per cycle while the output side keeps up; one table read-modify-write
// per word, a write followed at once by a read of the same entry is forwarded
// reset: asynchronous, active low; afterwards a clearing pass sets every table entry to all
// ones, during which no word is accepted; pool_bits resets to 0
module nonce_count_replay_table_core #(
	parameter int TABLE_BITS = ncrt_pkg::TABLE_BITS_DEF,
	parameter int ID_STEP    = ncrt_pkg::ID_STEP_DEF,
	parameter int COUNT_BITS = ncrt_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// nonce_id [31:0], pool [39:32], count_value [71:40], pool_current_id [103:72]
	input  logic [ncrt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// command [0]
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status [2:0], echoed_id [34:3], zero fill [39:35]
	output logic [ncrt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [ncrt_pkg::POOL_BITS_W-1:0]    cfg_wdata
);

	localparam int DEPTH = 2 ** TABLE_BITS;
	localparam int PK_W  = $clog2(TABLE_BITS + 1);
	localparam int IW    = ncrt_pkg::ID_W;

	// input fields
	logic                          in_cmd;
	logic [IW-1:0]                 in_id;
	logic [ncrt_pkg::POOL_W-1:0]   in_pool;
	logic [ncrt_pkg::CNT_IN_W-1:0] in_count;
	logic [IW-1:0]                 in_cur;

	assign in_cmd   = s_axis_tuser[0];
	assign in_id    = s_axis_tdata[31:0];
	assign in_pool  = s_axis_tdata[39:32];
	assign in_count = s_axis_tdata[71:40];
	assign in_cur   = s_axis_tdata[103:72];

	logic [ncrt_pkg::POOL_BITS_W-1:0] pool_bits_q;
	logic [TABLE_BITS:0]              clr_cnt_q;
	logic                             clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_bits_q <= '0;
		end else if (cfg_we) begin
			pool_bits_q <= cfg_wdata;
		end
	end

	assign clearing = !clr_cnt_q[TABLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// address and early tests on the incoming word
	logic [ncrt_pkg::POOL_BITS_W-1:0] pb_eff;
	logic [PK_W-1:0]                  part_k;
	logic [TABLE_BITS-1:0]            part_mask;
	logic [TABLE_BITS-1:0]            in_idx;
	logic [IW-1:0]                    age_limit;
	logic [IW-1:0]                    age_diff;
	logic                             in_pool_bad;
	logic                             in_aged;
	logic                             in_too_big;

	always_comb begin
		pb_eff      = (pool_bits_q > ncrt_pkg::POOL_BITS_MAX) ? ncrt_pkg::POOL_BITS_MAX
		                                                     : pool_bits_q;
		part_k      = PK_W'(TABLE_BITS) - PK_W'(pb_eff);
		part_mask   = ~({TABLE_BITS{1'b1}} << part_k);
		// masked id and shifted pool never overlap, so or stands for add
		in_idx      = (in_id[TABLE_BITS-1:0] & part_mask) | (TABLE_BITS'(in_pool) << part_k);
		age_limit   = IW'(ID_STEP) << part_k;
		age_diff    = in_cur - in_id;
		in_pool_bad = (in_pool >> pb_eff) != '0;
		in_aged     = age_diff >= age_limit;
		in_too_big  = |in_count[ncrt_pkg::CNT_IN_W-1:COUNT_BITS];
	end

	// stage 1: table data returns, decide and write back
	logic                   s1_valid_q;
	logic                   cmd_s1;
	logic [IW-1:0]          id_s1;
	logic [TABLE_BITS-1:0]  idx_s1;
	logic                   pool_bad_s1;
	logic                   aged_s1;
	logic                   too_big_s1;
	logic [COUNT_BITS-1:0]  count_s1;
	logic                   fwd_hit_s1;
	logic [COUNT_BITS-1:0]  fwd_data_s1;

	logic                   in_accept;
	logic                   s1_adv;
	logic [COUNT_BITS-1:0]  ram_rdata;
	logic [COUNT_BITS-1:0]  stored;
	ncrt_pkg::status_t      status_s1;
	logic                   upd_s1;
	logic                   ram_we;
	logic [TABLE_BITS-1:0]  ram_waddr;
	logic [COUNT_BITS-1:0]  ram_wdata;
	logic [COUNT_BITS-1:0]  upd_data;

	logic                   out_valid_q;
	ncrt_pkg::status_t      out_status_q;
	logic [IW-1:0]          out_id_q;

	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !clearing && (!s1_valid_q || s1_adv);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_comb begin
		stored = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
		priority if (cmd_s1 == ncrt_pkg::CMD_NEW) begin
			status_s1 = ncrt_pkg::STATUS_OK;
		end else if (pool_bad_s1) begin
			status_s1 = ncrt_pkg::STATUS_BAD_POOL;
		end else if (aged_s1) begin
			status_s1 = ncrt_pkg::STATUS_AGED;
		end else if (too_big_s1) begin
			status_s1 = ncrt_pkg::STATUS_TOO_BIG;
		end else if (stored >= count_s1) begin
			status_s1 = ncrt_pkg::STATUS_REPLAY;
		end else begin
			status_s1 = ncrt_pkg::STATUS_OK;
		end
		upd_s1   = s1_valid_q && s1_adv && (status_s1 == ncrt_pkg::STATUS_OK);
		upd_data = (cmd_s1 == ncrt_pkg::CMD_NEW) ? '0 : count_s1;
	end

	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q[TABLE_BITS-1:0];
			ram_wdata = '1;
		end else begin
			ram_we    = upd_s1;
			ram_waddr = idx_s1;
			ram_wdata = upd_data;
		end
	end

	ncrt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_accept),
		.raddr(in_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// the read of the new word and the write of the old one share an edge
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1      <= in_cmd;
			id_s1       <= in_id;
			idx_s1      <= in_idx;
			pool_bad_s1 <= in_pool_bad;
			aged_s1     <= in_aged;
			too_big_s1  <= in_too_big;
			count_s1    <= in_count[COUNT_BITS-1:0];
			fwd_hit_s1  <= upd_s1 && (idx_s1 == in_idx);
			fwd_data_s1 <= upd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			out_status_q <= status_s1;
			out_id_q     <= id_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_id_q, out_status_q};

endmodule

/* rtl/ncrt_ram.sv */
module ncrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* dv/nonce_count_replay_table_core_tb.sv */
module nonce_count_replay_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBW            = ncrt_pkg::TABLE_BITS_DEF;
	localparam int TABLE_DEPTH    = 1 << ncrt_pkg::TABLE_BITS_DEF;
	localparam int COUNT_MAX      = (1 << ncrt_pkg::COUNT_BITS_DEF) - 1;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int NUM_PHASES     = 9;
	localparam int PHASE_WORDS    = 75;

	typedef struct {
		ncrt_pkg::cmd_t cmd;
		logic [31:0]    id;
		logic [7:0]     pool;
		logic [31:0]    count;
		logic [31:0]    current_id;
	} nonce_word_t;

	typedef struct {
		ncrt_pkg::status_t status;
		logic [31:0]       echoed_id;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ncrt_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ncrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [ncrt_pkg::POOL_BITS_W-1:0] cfg_wdata = '0;

	nonce_word_t words_to_send[$];
	reply_t replies_due[$];

	logic [ncrt_pkg::COUNT_BITS_DEF-1:0] count_table [TABLE_DEPTH];
	logic [ncrt_pkg::POOL_BITS_W-1:0] pool_bits_cfg = '0;

	int words_queued = 0;
	int words_accepted = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit in_taken = 1'b0;

	// live nonces for the well-formed part of the random traffic
	bit [31:0] slot_id [8];
	bit [7:0] slot_pool [8];
	int slot_cnt [8];

	nonce_count_replay_table_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #10ns clk = ~clk;

	function automatic ncrt_pkg::status_t nonce_table_check(input ncrt_pkg::cmd_t cmd,
			input logic [31:0] id, input logic [7:0] pool, input logic [31:0] count,
			input logic [31:0] current_id);
		int unsigned pb;
		int unsigned part_k;
		logic [31:0] idx_w;
		logic [TBW-1:0] idx;
		int unsigned span;
		logic [31:0] age;
		pb = (pool_bits_cfg > ncrt_pkg::POOL_BITS_MAX) ? int'(ncrt_pkg::POOL_BITS_MAX)
		                                               : int'(pool_bits_cfg);
		part_k = ncrt_pkg::TABLE_BITS_DEF - pb;
		idx_w = (id & ((32'd1 << part_k) - 32'd1)) + (32'(pool) << part_k);
		idx = idx_w[TBW-1:0];
		span = ncrt_pkg::ID_STEP_DEF << part_k;
		age = current_id - id;
		// new nonce has no pool check, the index just wraps
		if (cmd == ncrt_pkg::CMD_NEW) begin
			count_table[idx] = '0;
			return ncrt_pkg::STATUS_OK;
		end
		if (int'(pool) >= (1 << pb))
			return ncrt_pkg::STATUS_BAD_POOL;
		if (age >= span)
			return ncrt_pkg::STATUS_AGED;
		if (count > COUNT_MAX)
			return ncrt_pkg::STATUS_TOO_BIG;
		if (32'(count_table[idx]) >= count)
			return ncrt_pkg::STATUS_REPLAY;
		count_table[idx] = count[ncrt_pkg::COUNT_BITS_DEF-1:0];
		return ncrt_pkg::STATUS_OK;
	endfunction

	task automatic add_word(input ncrt_pkg::cmd_t cmd, input logic [31:0] id,
			input logic [7:0] pool, input logic [31:0] count, input logic [31:0] current_id);
		nonce_word_t w;
		w.cmd = cmd;
		w.id = id;
		w.pool = pool;
		w.count = count;
		w.current_id = current_id;
		words_to_send.push_back(w);
		words_queued++;
	endtask

	task automatic gen_random(input int n);
		int k;
		logic [2:0] s;
		int r;
		int pb;
		int span;
		logic [31:0] id;
		logic [31:0] cur;
		logic [31:0] cnt;
		logic [7:0] pool;
		pb = (pool_bits_cfg > ncrt_pkg::POOL_BITS_MAX) ? int'(ncrt_pkg::POOL_BITS_MAX)
		                                               : int'(pool_bits_cfg);
		span = ncrt_pkg::ID_STEP_DEF << (ncrt_pkg::TABLE_BITS_DEF - pb);
		for (k = 0; k < n; k++) begin
			s = 3'($urandom_range(0, 7));
			r = $urandom_range(0, 99);
			if (r < 15) begin
				// small ids make slots share entries and hit back to back
				slot_id[s] = (r < 6) ? $urandom_range(0, 15) : $urandom;
				slot_pool[s] = (r < 2) ? 8'($urandom_range(0, 255))
				                       : 8'($urandom_range(0, (1 << pb) - 1));
				slot_cnt[s] = 0;
				add_word(ncrt_pkg::CMD_NEW, slot_id[s], slot_pool[s], $urandom, $urandom);
			end else if (r < 85) begin
				id = slot_id[s];
				pool = slot_pool[s];
				cur = id + $urandom_range(0, span - 1);
				if (r < 20)
					cnt = $urandom_range(slot_cnt[s], COUNT_MAX);
				else
					cnt = slot_cnt[s] + $urandom_range(0, 4);
				if (r >= 78 && r < 80)
					cur = (r == 78) ? id + span + $urandom_range(0, 3) : id - 1;
				else if (r >= 80 && r < 82)
					pool = 8'($urandom_range(1 << pb, 255));
				else if (r >= 82)
					cnt = $urandom;
				if (cnt > slot_cnt[s] && cnt <= COUNT_MAX)
					slot_cnt[s] = cnt;
				add_word(ncrt_pkg::CMD_CHECK, id, pool, cnt, cur);
			end else begin
				add_word(ncrt_pkg::cmd_t'($urandom_range(0, 1)), $urandom,
					8'($urandom_range(0, 255)), $urandom, $urandom);
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_accepted != words_queued || replies_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_pool_bits(input logic [ncrt_pkg::POOL_BITS_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_bits_cfg = value;
	endtask

	// sender: a word stays on the bus until taken
	always @(negedge clk) begin : sender
		nonce_word_t w;
		bit go;
		if (arst_n && !(s_axis_tvalid && !in_taken)) begin
			in_taken = 1'b0;
			go = words_to_send.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct;
			if (go) begin
				w = words_to_send.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {w.current_id, w.count, w.pool, w.id};
				s_axis_tuser <= w.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		reply_t due;
		logic [2:0] got_status;
		logic [31:0] got_id;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				due.status = nonce_table_check(ncrt_pkg::cmd_t'(s_axis_tuser[0]),
					s_axis_tdata[31:0], s_axis_tdata[39:32], s_axis_tdata[71:40],
					s_axis_tdata[103:72]);
				due.echoed_id = s_axis_tdata[31:0];
				replies_due.push_back(due);
				in_taken = 1'b1;
				words_accepted++;
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				got_status = m_axis_tdata[2:0];
				got_id = m_axis_tdata[34:3];
				if (replies_due.size() == 0) begin
					$error("result word with none due: status %0d echoed_id %h",
						got_status, got_id);
					mismatches++;
				end else begin
					due = replies_due.pop_front();
					if (got_status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, got_status);
						mismatches++;
					end
					if (got_id !== due.echoed_id) begin
						$error("echoed_id: expected %h, got %h", due.echoed_id, got_id);
						mismatches++;
					end
				end
			end
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int ph;
		logic [ncrt_pkg::POOL_BITS_W-1:0] cfg_seq [NUM_PHASES-1];
		cfg_seq = '{3'd4, 3'd2, 3'd7, 3'd1, 3'd0, 3'd3, 3'd6, 3'd5};
		count_table = '{default: '1};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// pool_bits at reset value: one partition of the whole table
		snd_idle_pct = 8;
		rcv_idle_pct = 55;
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd0, 32'd1, 32'd5);
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd0, 32'd255, 32'd5);
		add_word(ncrt_pkg::CMD_NEW, 32'd5, 8'd0, 32'hffff_ffff, 32'hffff_ffff);
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd0, 32'd1, 32'd5);
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd0, 32'd1, 32'd5);
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd0, 32'd0, 32'd5);
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd0, 32'd255, 32'd5);
		add_word(ncrt_pkg::CMD_CHECK, 32'd5, 8'd1, 32'd1, 32'd5);
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd255, 32'd1, 32'hffff_ffff);
		add_word(ncrt_pkg::CMD_CHECK, 32'd0, 8'd0, 32'd1, 32'd1024);
		add_word(ncrt_pkg::CMD_CHECK, 32'd0, 8'd0, 32'd1, 32'd1023);
		add_word(ncrt_pkg::CMD_NEW, 32'hffff_ffff, 8'd0, 32'd0, 32'd0);
		// id just behind the current id across the 32-bit wrap
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd0, 32'd256, 32'd0);
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd0, 32'hffff_ffff, 32'd0);
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd0, 32'd200, 32'd0);
		add_word(ncrt_pkg::CMD_CHECK, 32'd10, 8'd0, 32'd1, 32'd9);
		// out of range pool on a new nonce still zeroes an entry
		add_word(ncrt_pkg::CMD_NEW, 32'h0000_0123, 8'd255, 32'd7, 32'd7);
		add_word(ncrt_pkg::CMD_CHECK, 32'h0000_0123, 8'd0, 32'd1, 32'h0000_0123);
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd0, 32'd0, 32'hffff_ffff);
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd0, 32'd201, 32'hffff_ffff);
		add_word(ncrt_pkg::CMD_CHECK, 32'hffff_ffff, 8'd0, 32'd201, 32'hffff_ffff);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph >= 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end else if (ph >= 3) begin
				snd_idle_pct = 55;
				rcv_idle_pct = 8;
			end
			// long output stall while words keep coming, to back the block up
			if (ph == 6)
				hold_req = 1'b1;
			gen_random(PHASE_WORDS);
			wait_drained();
			gen_random(PHASE_WORDS);
			wait_drained();
			if (ph < NUM_PHASES - 1)
				write_pool_bits(cfg_seq[ph[2:0]]);
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/ncrt_pkg.sv
rtl/ncrt_ram.sv
rtl/nonce_count_replay_table_core.sv
dv/nonce_count_replay_table_core_tb.sv
